/* rtl/keyword_highlight_tagger_assert.svh */
// assertion macros shared by the checker
`ifndef KEYWORD_HIGHLIGHT_TAGGER_ASSERT_SVH
`define KEYWORD_HIGHLIGHT_TAGGER_ASSERT_SVH

// same-cycle implication
`define KHT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("keyword_highlight_tagger: assertion failed");

// next-cycle implication
`define KHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("keyword_highlight_tagger: assertion failed");

`endif

/* rtl/kht_pkg.sv */
package kht_pkg;

	localparam int NUM_KEYS    = 6;
	localparam int KEY_BYTES   = 8;
	localparam int WIN_DEPTH   = KEY_BYTES;
	localparam int FIFO_DEPTH  = 4;

	localparam int KEY_REG_W   = 64;
	localparam int LEN_REG_W   = 24;
	localparam int STYLE_REG_W = 56;
	localparam int LEN_FIELD_W = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	localparam int FILL_W  = $clog2(WIN_DEPTH + 1);
	localparam int POS_W   = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
	localparam int SLOT_W  = $clog2(NUM_KEYS + 1);

	localparam logic [CFG_IDX_W-1:0] REG_KEY_FIRST = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LAST  = CFG_IDX_W'(NUM_KEYS - 1);
	localparam logic [CFG_IDX_W-1:0] REG_LENGTHS   = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_STYLES    = CFG_IDX_W'(7);

	localparam int DEFAULT_STYLE_SLOT = 6;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       segment_end;
	} text_word_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic [7:0] byte_style;
		logic       last_of_segment;
	} tag_word_t;

	typedef struct packed {
		logic [NUM_KEYS-1:0][KEY_REG_W-1:0] keys;
		logic [LEN_REG_W-1:0]               lengths;
		logic [STYLE_REG_W-1:0]             styles;
	} cfg_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (c inside {[8'h41:8'h5A]}) begin
			return c + 8'h20;
		end
		return c;
	endfunction

endpackage

/* rtl/kht_front.sv */
module kht_front (
	input  logic              clk,
	input  logic              arst_n,
	input  kht_pkg::cfg_t     cfg,
	input  logic              text_valid,
	output logic              text_ready,
	input  kht_pkg::text_word_t text,
	output logic              push_valid,
	input  logic              push_ready,
	output kht_pkg::tag_word_t push_word
);
	import kht_pkg::*;

	logic [7:0]             win_q [WIN_DEPTH];
	logic [WIN_DEPTH-1:0]   lst_q;
	logic [FILL_W-1:0]      fill_q;
	logic [POS_W-1:0]       cov_rem_q;
	logic [7:0]             cov_style_q;

	logic [7:0]             win_n [WIN_DEPTH];
	logic [WIN_DEPTH-1:0]   lst_n;
	logic [WIN_DEPTH-1:0]   vmask;
	logic                   seg_end;
	logic                   full;
	logic [FILL_W-1:0]      avail;
	logic [LEN_FIELD_W-1:0] key_len [NUM_KEYS];
	logic [NUM_KEYS-1:0]    hit;
	logic                   any_hit;
	logic [SLOT_W-1:0]      sel;
	logic [LEN_FIELD_W-1:0] hit_len;
	logic [7:0]             style;
	logic                   emit;
	logic                   acc;
	logic [FILL_W-1:0]      fill_after;
	logic [POS_W-1:0]       wr_pos;

	// extent of the current segment inside the window
	always_comb begin
		avail = fill_q;
		seg_end = 1'b0;
		for (int i = WIN_DEPTH - 1; i >= 0; i--) begin
			vmask[i] = FILL_W'(i) < fill_q;
			if (vmask[i] && lst_q[i]) begin
				avail = FILL_W'(i + 1);
				seg_end = 1'b1;
			end
		end
	end

	// all slots against the window in parallel
	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			key_len[k] = cfg.lengths[LEN_FIELD_W*k +: LEN_FIELD_W];
			hit[k] = (key_len[k] != '0) && (key_len[k] <= LEN_FIELD_W'(KEY_BYTES))
				&& (key_len[k] <= LEN_FIELD_W'(avail));
			for (int i = 0; i < KEY_BYTES; i++) begin
				if (LEN_FIELD_W'(i) < key_len[k]
					&& fold_case(cfg.keys[k][8*i +: 8]) != fold_case(win_q[i])) begin
					hit[k] = 1'b0;
				end
			end
		end
	end

	// lowest slot wins; a running keyword cover keeps its style, and no hit gives the default style
	always_comb begin
		any_hit = 1'b0;
		sel = '0;
		for (int k = NUM_KEYS - 1; k >= 0; k--) begin
			if (hit[k]) begin
				any_hit = 1'b1;
				sel = SLOT_W'(k);
			end
		end
		hit_len = key_len[sel];
		if (cov_rem_q != '0) begin
			style = cov_style_q;
		end else if (any_hit) begin
			style = cfg.styles[8*sel +: 8];
		end else begin
			style = cfg.styles[8*DEFAULT_STYLE_SLOT +: 8];
		end
	end

	assign full       = fill_q == FILL_W'(WIN_DEPTH);
	assign push_valid = (fill_q != '0) && (full || seg_end);
	assign emit       = push_valid && push_ready;
	assign text_ready = !full || emit;
	assign acc        = text_valid && text_ready;
	assign fill_after = fill_q - FILL_W'(emit);
	assign wr_pos     = fill_after[POS_W-1:0];

	assign push_word.byte_value      = win_q[0];
	assign push_word.byte_style      = style;
	assign push_word.last_of_segment = lst_q[0];

	always_comb begin
		for (int i = 0; i < WIN_DEPTH; i++) begin
			win_n[i] = win_q[i];
		end
		lst_n = lst_q;
		if (emit) begin
			for (int i = 0; i < WIN_DEPTH - 1; i++) begin
				win_n[i] = win_q[i + 1];
			end
			lst_n = lst_q >> 1;
		end
		if (acc) begin
			win_n[wr_pos] = text.text_byte;
			lst_n[wr_pos] = text.segment_end;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < WIN_DEPTH; i++) begin
			win_q[i] <= win_n[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lst_q       <= '0;
			fill_q      <= '0;
			cov_rem_q   <= '0;
			cov_style_q <= '0;
		end else begin
			lst_q  <= lst_n;
			fill_q <= fill_after + FILL_W'(acc);
			if (emit) begin
				if (lst_q[0]) begin
					cov_rem_q <= '0;
				end else if (cov_rem_q != '0) begin
					cov_rem_q <= cov_rem_q - POS_W'(1);
				end else if (any_hit) begin
					cov_rem_q   <= POS_W'(hit_len - LEN_FIELD_W'(1));
					cov_style_q <= style;
				end
			end
		end
	end

endmodule

/* rtl/kht_fifo.sv */
module kht_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  kht_pkg::tag_word_t push_word,
	output logic               pop_valid,
	input  logic               pop_ready,
	output kht_pkg::tag_word_t pop_word
);
	import kht_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	tag_word_t         mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = cnt_q != CNT_W'(FIFO_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_word   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

/* rtl/keyword_highlight_tagger.sv */
// channel  | signals                     | word
// text     | text_valid / text_ready     | text_byte, segment_end
// tag      | tag_valid / tag_ready       | byte_value, byte_style, last_of_segment
// cfg      | cfg_we, cfg_index, cfg_wdata| one register per write, no wait
//
// one word per cycle in and out once the window is primed, while the tag side keeps taking words
// a byte leaves the eight-byte window when seven later bytes or its segment end
// are in and the queue has room, then passes through the four-word queue
// text stalls only while the window is full and the queue is full
// reset clears window fill, keyword cover, queue and all config registers
module keyword_highlight_tagger (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                text_valid,
	output logic                                text_ready,
	input  kht_pkg::text_word_t                 text,
	output logic                                tag_valid,
	input  logic                                tag_ready,
	output kht_pkg::tag_word_t                  tag,
	input  logic                                cfg_we,
	input  logic [kht_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kht_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import kht_pkg::*;

	cfg_t      cfg_q;
	logic      push_valid;
	logic      push_ready;
	tag_word_t push_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index inside {[REG_KEY_FIRST:REG_KEY_LAST]}) begin
				cfg_q.keys[cfg_index] <= cfg_wdata[KEY_REG_W-1:0];
			end else if (cfg_index == REG_LENGTHS) begin
				cfg_q.lengths <= cfg_wdata[LEN_REG_W-1:0];
			end else if (cfg_index == REG_STYLES) begin
				cfg_q.styles <= cfg_wdata[STYLE_REG_W-1:0];
			end
		end
	end

	kht_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text       (text),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word)
	);

	kht_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word),
		.pop_valid  (tag_valid),
		.pop_ready  (tag_ready),
		.pop_word   (tag)
	);

endmodule

/* rtl/kht_checker.sv */
`include "keyword_highlight_tagger_assert.svh"

module kht_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                text_valid,
	input logic                text_ready,
	input logic                tag_valid,
	input logic                tag_ready,
	input kht_pkg::tag_word_t  tag
);
	import kht_pkg::*;

	localparam int HELD   = WIN_DEPTH + FIFO_DEPTH;
	localparam int PEND_W = $clog2(HELD + 2);

	logic [PEND_W-1:0] pending_q;
	logic              text_acc;
	logic              tag_acc;

	assign text_acc = text_valid && text_ready;
	assign tag_acc  = tag_valid && tag_ready;

	// bytes taken in but not yet handed out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + PEND_W'(text_acc) - PEND_W'(tag_acc);
		end
	end

	`KHT_ASSERT_NEXT(a_tag_held, clk, arst_n, tag_valid && !tag_ready, tag_valid)
	`KHT_ASSERT_NEXT(a_tag_stable, clk, arst_n, tag_valid && !tag_ready, $stable(tag))
	`KHT_ASSERT_IMPL(a_no_invented, clk, arst_n, tag_valid, pending_q != '0)
	`KHT_ASSERT_IMPL(a_stall_full, clk, arst_n, !text_ready, pending_q >= PEND_W'(WIN_DEPTH))
	`KHT_ASSERT_IMPL(a_bounded, clk, arst_n, 1'b1, pending_q <= PEND_W'(HELD))

endmodule

bind keyword_highlight_tagger kht_checker u_kht_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.text_valid (text_valid),
	.text_ready (text_ready),
	.tag_valid  (tag_valid),
	.tag_ready  (tag_ready),
	.tag        (tag)
);
